>>> rtl/spp_pkg.sv
`default_nettype none

package spp_pkg;

  localparam int unsigned ADDR_BITS      = 48;
  localparam int unsigned PAGE_BITS      = 12;
  localparam int unsigned PN_BITS        = ADDR_BITS - PAGE_BITS;
  localparam int unsigned CNT_BITS       = 6;
  localparam int unsigned IDX_BITS       = CNT_BITS + 1;
  localparam int unsigned FILL_BITS      = 3;
  localparam int unsigned STRIDE_WINDOW  = 4;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = CNT_BITS;

  localparam logic [PN_BITS-1:0]   STRIDE_MAX_PAGES = PN_BITS'(256);
  localparam logic                 PREFETCH_ENABLE_RST = 1'b1;
  localparam logic [CNT_BITS-1:0]  SEQUENTIAL_COUNT_RST = CNT_BITS'(16);
  localparam logic [CNT_BITS-1:0]  STRIDE_COUNT_RST = CNT_BITS'(8);

  typedef enum logic [1:0] {
    KIND_DEMAND = 2'd0,
    KIND_SEQ    = 2'd1,
    KIND_STRIDE = 2'd2,
    KIND_HIT    = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PREFETCH_ENABLE  = 2'd0,
    CFG_SEQUENTIAL_COUNT = 2'd1,
    CFG_STRIDE_COUNT     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] fault_address;
    logic                 already_served;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] target_page;
    kind_e                request_kind;
    logic                 last_of_run;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic adv;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic last;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/spp_ctrl.sv
`default_nettype none

module spp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire spp_pkg::status_t status_i,
  output spp_pkg::cmd_t         cmd_o
);

  spp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = spp_pkg::ST_RUN;
      end
      spp_pkg::ST_RUN: begin
        if (!status_i.skip && status_i.slot_free && status_i.last) state_d = spp_pkg::ST_IDLE;
      end
      default: state_d = spp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      spp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      spp_pkg::ST_RUN: begin
        cmd_o.emit = !status_i.skip && status_i.slot_free;
        cmd_o.adv  = status_i.skip || cmd_o.emit;
        cmd_o.done = cmd_o.emit && status_i.last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> (state_q == spp_pkg::ST_IDLE))
    else $error("run did not end after its last word");

  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spp_pkg::ST_RUN) |-> (!in_ready_o && !cmd_o.load))
    else $error("input taken while a run is in progress");

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (status_i.slot_free && !status_i.skip))
    else $error("word emitted into a busy output slot");

endmodule

`default_nettype wire

>>> rtl/spp_datapath.sv
`default_nettype none

module spp_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire spp_pkg::in_word_t                  in_word_i,
  input  wire spp_pkg::cmd_t                      cmd_i,
  output spp_pkg::status_t                        status_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output spp_pkg::out_word_t                      out_word_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [spp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [spp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  localparam int unsigned PNB = spp_pkg::PN_BITS;
  localparam int unsigned CB  = spp_pkg::CNT_BITS;
  localparam int unsigned IB  = spp_pkg::IDX_BITS;

  // configuration
  logic          pf_en_q;
  logic [CB-1:0] seq_cnt_q;
  logic [CB-1:0] str_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_en_q   <= spp_pkg::PREFETCH_ENABLE_RST;
      seq_cnt_q <= spp_pkg::SEQUENTIAL_COUNT_RST;
      str_cnt_q <= spp_pkg::STRIDE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (spp_pkg::cfg_idx_e'(cfg_index_i))
        spp_pkg::CFG_PREFETCH_ENABLE:  pf_en_q   <= cfg_wdata_i[0];
        spp_pkg::CFG_SEQUENTIAL_COUNT: seq_cnt_q <= cfg_wdata_i;
        spp_pkg::CFG_STRIDE_COUNT:     str_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // history: the last four recorded pages, oldest in slot 0
  logic [PNB-1:0] hist_q [spp_pkg::STRIDE_WINDOW];
  logic [spp_pkg::FILL_BITS-1:0] fill_q;

  logic [PNB-1:0] d1, d2, d3, mag;
  logic           stride_ok;

  always_comb begin
    d1  = hist_q[1] - hist_q[0];
    d2  = hist_q[2] - hist_q[1];
    d3  = hist_q[3] - hist_q[2];
    mag = d1[PNB-1] ? (~d1 + PNB'(1)) : d1;
    stride_ok = (fill_q >= spp_pkg::FILL_BITS'(spp_pkg::STRIDE_WINDOW)) &&
                (d1 == d2) && (d2 == d3) && (d1 != '0) &&
                (mag <= spp_pkg::STRIDE_MAX_PAGES);
  end

  // run registers
  logic [PNB-1:0] pn_q, acc_q, step_q, nxt;
  logic [IB-1:0]  idx_q, idx_inc;
  logic [CB-1:0]  cnt_q;
  logic           served_q, stride_q;

  assign nxt     = acc_q + step_q;
  assign idx_inc = idx_q + IB'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pn_q     <= in_word_i.fault_address[spp_pkg::ADDR_BITS-1:spp_pkg::PAGE_BITS];
      acc_q    <= in_word_i.fault_address[spp_pkg::ADDR_BITS-1:spp_pkg::PAGE_BITS];
      idx_q    <= '0;
      served_q <= in_word_i.already_served;
      stride_q <= stride_ok;
      step_q   <= stride_ok ? d1 : PNB'(1);
      cnt_q    <= !pf_en_q ? '0 : (stride_ok ? str_cnt_q : seq_cnt_q);
    end else if (cmd_i.adv) begin
      acc_q <= nxt;
      idx_q <= idx_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done && !served_q) begin
      hist_q[0] <= hist_q[1];
      hist_q[1] <= hist_q[2];
      hist_q[2] <= hist_q[3];
      hist_q[3] <= pn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.done && !served_q &&
                 (fill_q < spp_pkg::FILL_BITS'(spp_pkg::STRIDE_WINDOW))) begin
      fill_q <= fill_q + spp_pkg::FILL_BITS'(1);
    end
  end

  // output register
  logic               out_valid_q;
  spp_pkg::out_word_t out_word_q;
  spp_pkg::kind_e     kind;

  always_comb begin
    if (idx_q == '0) kind = served_q ? spp_pkg::KIND_HIT : spp_pkg::KIND_DEMAND;
    else             kind = stride_q ? spp_pkg::KIND_STRIDE : spp_pkg::KIND_SEQ;
  end

  assign status_o.skip      = stride_q && (idx_q != '0) && (acc_q == '0);
  // a zero stride target at the final index would be dropped, so look one ahead
  assign status_o.last      = served_q || (idx_q == {1'b0, cnt_q}) ||
                              ((idx_inc == {1'b0, cnt_q}) && stride_q && (nxt == '0));
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q.target_page  <= {acc_q, {spp_pkg::PAGE_BITS{1'b0}}};
      out_word_q.request_kind <= kind;
      out_word_q.last_of_run  <= status_o.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_skip_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.skip |-> (idx_q != '0))
    else $error("first word of a run marked as skipped");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.done && !served_q) |=> (fill_q != '0))
    else $error("recorded page not counted in history fill");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.adv |-> (idx_q <= {1'b0, cnt_q}))
    else $error("run index beyond prefetch count");

endmodule

`default_nettype wire

>>> rtl/stride_page_prefetcher_top.sv
// After a fault is accepted, its first word passes through the run registers into the output register.
// Each fault yields N words out (one hit, or a demand plus prefetches); a stride target
// at page zero is dropped. Unless the output slot is full or a target is dropped, the
// run sequencer emits one word per cycle into a single output register.
// Reset (rst_ni low, asynchronous) empties the history and output, and sets the
// registers to prefetch on, 16 sequential pages and 8 stride pages.
`default_nettype none

module stride_page_prefetcher_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // fault word in
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire spp_pkg::in_word_t                  in_word_i,
  // request word out
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output spp_pkg::out_word_t                      out_word_o,
  // register writes
  input  wire logic                               cfg_we_i,
  input  wire logic [spp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [spp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  spp_pkg::cmd_t    cmd;
  spp_pkg::status_t status;

  // Controller: wait for a fault word, then step the run one word per
  // cycle, holding whenever the output slot is still full.
  spp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: stride detection on the last four pages, the target
  // accumulator, the history shift line, the output register and the
  // configuration registers.
  spp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

`default_nettype wire

>>> verif/tb_stride_page_prefetcher_top.sv
`timescale 1ns / 1ps

module tb_stride_page_prefetcher_top;

  localparam int unsigned HIST_DEPTH      = 8;
  // Slowest legal run: ~410 faults x 64 words, each behind a worst-case output stall, plus
  // input gaps and the long hold-off; allow roughly four times that.
  localparam int unsigned WATCHDOG_CYCLES = 1_000_000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS     = 77;
  localparam int unsigned MAX_LOGGED      = 100;
  localparam logic [spp_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [spp_pkg::PN_BITS-1:0]      PN_TOP     = '1;

  // Scoreboard: predicts the words of each accepted fault and checks the
  // words that leave the block against them, oldest first.
  class fetch_plan_board;
    spp_pkg::out_word_t           pending[$];
    logic [spp_pkg::PN_BITS-1:0]  hist_pages[HIST_DEPTH];
    int unsigned                  hist_pos;
    int unsigned                  hist_fill;
    logic                         pf_en;
    logic [spp_pkg::CNT_BITS-1:0] seq_cnt;
    logic [spp_pkg::CNT_BITS-1:0] str_cnt;
    int unsigned                  errors;

    function new();
      foreach (hist_pages[i]) hist_pages[i] = '0;
      hist_pos  = 0;
      hist_fill = 0;
      pf_en     = spp_pkg::PREFETCH_ENABLE_RST;
      seq_cnt   = spp_pkg::SEQUENTIAL_COUNT_RST;
      str_cnt   = spp_pkg::STRIDE_COUNT_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [spp_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [spp_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        spp_pkg::CFG_PREFETCH_ENABLE:  pf_en   = val[0];
        spp_pkg::CFG_SEQUENTIAL_COUNT: seq_cnt = val;
        spp_pkg::CFG_STRIDE_COUNT:     str_cnt = val;
        default: ;
      endcase
    endfunction

    // Three equal nonzero steps over the last four pages, magnitude 1 to 256.
    function bit find_step(output logic [spp_pkg::PN_BITS-1:0] step);
      logic [spp_pkg::PN_BITS-1:0] p[4];
      logic [spp_pkg::PN_BITS-1:0] d1, d2, d3, mag;
      int i;
      step = '0;
      if (hist_fill < 4) return 1'b0;
      for (i = 0; i < 4; i++) p[i] = hist_pages[(hist_pos + HIST_DEPTH - 4 + i) % HIST_DEPTH];
      d1 = p[1] - p[0];
      d2 = p[2] - p[1];
      d3 = p[3] - p[2];
      if (d1 != d2 || d2 != d3 || d1 == '0) return 1'b0;
      mag = d1[spp_pkg::PN_BITS-1] ? -d1 : d1;
      if (mag > spp_pkg::STRIDE_MAX_PAGES) return 1'b0;
      step = d1;
      return 1'b1;
    endfunction

    function void note_fault(spp_pkg::in_word_t w);
      logic [spp_pkg::PN_BITS-1:0] pn, step, tgt;
      spp_pkg::out_word_t o;
      int i;
      pn            = w.fault_address[spp_pkg::ADDR_BITS-1:spp_pkg::PAGE_BITS];
      o.target_page = {pn, {spp_pkg::PAGE_BITS{1'b0}}};
      o.last_of_run = 1'b0;
      if (w.already_served) begin
        o.request_kind = spp_pkg::KIND_HIT;
        o.last_of_run  = 1'b1;
        pending.push_back(o);
        return;
      end
      o.request_kind = spp_pkg::KIND_DEMAND;
      pending.push_back(o);
      // Counts top out at 63, so a run holds at most 63 prefetches.
      if (pf_en) begin
        if (find_step(step)) begin
          o.request_kind = spp_pkg::KIND_STRIDE;
          for (i = 1; i <= str_cnt; i++) begin
            tgt = pn + spp_pkg::PN_BITS'(i) * step;
            // drop a target at page zero without lengthening the run
            if (tgt != '0) begin
              o.target_page = {tgt, {spp_pkg::PAGE_BITS{1'b0}}};
              pending.push_back(o);
            end
          end
        end else begin
          o.request_kind = spp_pkg::KIND_SEQ;
          for (i = 1; i <= seq_cnt; i++) begin
            tgt           = pn + spp_pkg::PN_BITS'(i);
            o.target_page = {tgt, {spp_pkg::PAGE_BITS{1'b0}}};
            pending.push_back(o);
          end
        end
      end
      hist_pages[hist_pos] = pn;
      hist_pos = (hist_pos + 1) % HIST_DEPTH;
      if (hist_fill < HIST_DEPTH) hist_fill++;
      o = pending.pop_back();
      o.last_of_run = 1'b1;
      pending.push_back(o);
    endfunction

    task report(string msg);
      // keep the log short; count every one
      if (errors < MAX_LOGGED) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(spp_pkg::out_word_t got);
      spp_pkg::out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word page %h kind %0d", got.target_page, got.request_kind));
        return;
      end
      want = pending.pop_front();
      if (got.target_page !== want.target_page)
        report($sformatf("target_page %h, want %h", got.target_page, want.target_page));
      if (got.request_kind !== want.request_kind)
        report($sformatf("request_kind %0d, want %0d at page %h", got.request_kind,
                         want.request_kind, want.target_page));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %b, want %b at page %h", got.last_of_run,
                         want.last_of_run, want.target_page));
    endtask
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  spp_pkg::in_word_t                 in_word_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  spp_pkg::out_word_t                out_word_o;
  logic                              cfg_we_i;
  logic [spp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [spp_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i;

  // Pacing flags shared between the stimulus and the receiver.
  bit idle_on;
  bit hold_req;

  fetch_plan_board board = new();

  stride_page_prefetcher_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Build a fault on a given page with a random byte offset.
  function automatic spp_pkg::in_word_t fault_at(logic [spp_pkg::PN_BITS-1:0] pn,
                                                 logic served);
    spp_pkg::in_word_t w;
    w.fault_address  = {pn, spp_pkg::PAGE_BITS'($urandom)};
    w.already_served = served;
    return w;
  endfunction

  // Offer one fault word, with an optional gap first, and hold it until taken.
  // Inputs move on the falling edge; the handshake is sampled on the rising edge.
  task automatic send_fault(input spp_pkg::in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_fault(w);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every predicted word to arrive, then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all three registers back to back, optionally poking the unused index.
  task automatic apply_settings(input logic [spp_pkg::CFG_DATA_BITS-1:0] en_val,
                                input logic [spp_pkg::CFG_DATA_BITS-1:0] seq_val,
                                input logic [spp_pkg::CFG_DATA_BITS-1:0] str_val,
                                input bit poke_unused);
    logic [spp_pkg::CFG_DATA_BITS-1:0] vals[4];
    logic [spp_pkg::CFG_IDX_BITS-1:0]  regs[4];
    int r;
    vals[0] = en_val;
    vals[1] = seq_val;
    vals[2] = str_val;
    vals[3] = spp_pkg::CFG_DATA_BITS'($urandom);
    regs[0] = spp_pkg::CFG_PREFETCH_ENABLE;
    regs[1] = spp_pkg::CFG_SEQUENTIAL_COUNT;
    regs[2] = spp_pkg::CFG_STRIDE_COUNT;
    regs[3] = CFG_UNUSED;
    for (r = 0; r < 4; r++) begin
      if (r < 3 || poke_unused) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= regs[r];
        cfg_wdata_i <= vals[r];
        @(negedge clk_i);
        board.write_reg(regs[r], vals[r]);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly constant-step page streams with random content, the rest noise.
  task automatic run_random_phase(input int unsigned items);
    int unsigned sent, len, k;
    logic [spp_pkg::PN_BITS-1:0] pn, step;
    spp_pkg::in_word_t w;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0) pn = spp_pkg::PN_BITS'({$urandom, $urandom});
        else pn = spp_pkg::PN_BITS'($urandom_range(0, 4096));
        case ($urandom_range(0, 7))
          0:       step = spp_pkg::PN_BITS'($urandom_range(257, 4000));
          1:       step = spp_pkg::STRIDE_MAX_PAGES;
          2:       step = spp_pkg::PN_BITS'(1);
          3:       step = '0;
          default: step = spp_pkg::PN_BITS'($urandom_range(1, 256));
        endcase
        if ($urandom_range(0, 1) == 0) step = -step;
        len = $urandom_range(4, 8);
        for (k = 0; k < len && sent < items; k++) begin
          w = fault_at(pn, $urandom_range(0, 9) == 0);
          send_fault(w);
          sent++;
          // a resident page leaves the history alone, so hold the stream position
          if (!w.already_served) pn = pn + step;
        end
      end else begin
        w.fault_address  = spp_pkg::ADDR_BITS'({$urandom, $urandom});
        w.already_served = ($urandom_range(0, 3) == 0);
        send_fault(w);
        sent++;
      end
    end
  endtask

  // Check every word that leaves the block.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_word(out_word_o);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rx_pacer
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    spp_pkg::in_word_t w;
    logic [spp_pkg::PN_BITS-1:0] pn;
    int k;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset settings.
    // Page zero on an empty history: sequential run, no stride possible yet.
    send_fault(fault_at('0, 1'b0));
    // Top address resident: a single hit word.
    w.fault_address  = '1;
    w.already_served = 1'b1;
    send_fault(w);
    // Top address missing: sequential targets wrap through page zero.
    w.already_served = 1'b0;
    send_fault(w);
    // Step of minus 256 pages: the fifth fault sees the stride.
    pn = spp_pkg::PN_BITS'(36'h5000);
    for (k = 0; k < 5; k++) begin
      send_fault(fault_at(pn, 1'b0));
      pn = pn - spp_pkg::STRIDE_MAX_PAGES;
    end
    // Step of 257 pages is too wide: stays sequential.
    pn = spp_pkg::PN_BITS'(36'h20000);
    for (k = 0; k < 5; k++) begin
      send_fault(fault_at(pn, 1'b0));
      pn = pn + spp_pkg::PN_BITS'(257);
    end
    // Falling stride towards page zero with a hit in the middle; the zero target is dropped.
    pn = spp_pkg::PN_BITS'(6);
    for (k = 0; k < 5; k++) begin
      if (k == 3) send_fault(fault_at(spp_pkg::PN_BITS'({$urandom, $urandom}), 1'b1));
      send_fault(fault_at(pn, 1'b0));
      pn = pn - spp_pkg::PN_BITS'(1);
    end
    // Rising stride at the top of the page space wraps past page zero.
    pn = PN_TOP - spp_pkg::PN_BITS'(4);
    for (k = 0; k < 5; k++) begin
      send_fault(fault_at(pn, 1'b0));
      pn = pn + spp_pkg::PN_BITS'(1);
    end
    wait_drained();

    // Longest runs; hold the receiver off so the block backs up onto its input.
    apply_settings(spp_pkg::CFG_DATA_BITS'(1), '1, '1, 1'b0);
    hold_req = 1'b1;
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    // Prefetch off, written with the upper bits set to check the masking.
    apply_settings(spp_pkg::CFG_DATA_BITS'(6'b111110), spp_pkg::CFG_DATA_BITS'($urandom),
                   spp_pkg::CFG_DATA_BITS'($urandom), 1'b1);
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    // Prefetch on with zero counts: demand or hit words only.
    apply_settings(spp_pkg::CFG_DATA_BITS'(6'b101011), '0, '0, 1'b0);
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    // Random moderate counts.
    apply_settings(spp_pkg::CFG_DATA_BITS'(1), spp_pkg::CFG_DATA_BITS'($urandom_range(0, 24)),
                   spp_pkg::CFG_DATA_BITS'($urandom_range(0, 24)), 1'b1);
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    apply_settings(spp_pkg::CFG_DATA_BITS'(1), spp_pkg::SEQUENTIAL_COUNT_RST,
                   spp_pkg::STRIDE_COUNT_RST, 1'b0);
    run_random_phase(PHASE_ITEMS);
    wait_drained();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
